>>> rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants, item types and the arctangent table of the cartesian to
// spherical map.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int ANG_BITS      = 30;
  localparam int ANG_SH        = ANG_BITS - FRAC_BITS;
  localparam int SQRT_STEPS    = 32;
  localparam int LANE_W        = 48;
  localparam int ACC_W         = 36;

  localparam logic signed [ACC_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic [17:0] PI_F =
    18'((64'(PI_Q30) + (64'd1 << (ANG_SH - 1))) >> ANG_SH);

  typedef enum logic [2:0] {
    CFG_RADIUS_MAX = 3'd0,
    CFG_INV_RADIUS = 3'd1,
    CFG_OMEGA      = 3'd2,
    CFG_TOLERANCE  = 3'd3,
    CFG_TIME_LIMIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [ACC_W-1:0]  acc;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0]        sq_x;
    logic [63:0]        sq_y;
    logic [63:0]        sq_z;
    logic [63:0]        t_prod;
    logic               t_neg;
    logic               t_in;
    logic signed [31:0] ts;
    logic [63:0]        rem_r;
    logic [63:0]        res_r;
    logic [63:0]        rem_p;
    logic [63:0]        res_p;
    logic [63:0]        r_prod;
    logic               r_in;
    logic               axis;
    logic               z_neg;
    lane_t              th;
    lane_t              ph;
  } item_t;

  function automatic logic signed [ACC_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ACC_W-1:0] a;
    case (idx)
      5'd0:  a = 36'sd843314856;
      5'd1:  a = 36'sd497837829;
      5'd2:  a = 36'sd263043836;
      5'd3:  a = 36'sd133525158;
      5'd4:  a = 36'sd67021686;
      5'd5:  a = 36'sd33543515;
      5'd6:  a = 36'sd16775850;
      5'd7:  a = 36'sd8388437;
      5'd8:  a = 36'sd4194282;
      5'd9:  a = 36'sd2097149;
      5'd10: a = 36'sd1048575;
      5'd11: a = 36'sd524287;
      5'd12: a = 36'sd262143;
      5'd13: a = 36'sd131071;
      5'd14: a = 36'sd65535;
      5'd15: a = 36'sd32767;
      5'd16: a = 36'sd16383;
      5'd17: a = 36'sd8191;
      5'd18: a = 36'sd4095;
      5'd19: a = 36'sd2047;
      5'd20: a = 36'sd1023;
      5'd21: a = 36'sd511;
      5'd22: a = 36'sd255;
      5'd23: a = 36'sd127;
      5'd24: a = 36'sd63;
      5'd25: a = 36'sd31;
      5'd26: a = 36'sd15;
      5'd27: a = 36'sd7;
      5'd28: a = 36'sd3;
      5'd29: a = 36'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/c2s_if.sv
// ----------------------------------------------------------------------------
// c2s_in_if / c2s_out_if
// Valid/ready channels carrying one point and one mapped result per beat.
// ----------------------------------------------------------------------------
interface c2s_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic signed [31:0] z_pos;
  logic signed [31:0] time_pos;
  modport source (output valid, x_pos, y_pos, z_pos, time_pos, input ready);
  modport sink   (input valid, x_pos, y_pos, z_pos, time_pos, output ready);
endinterface

interface c2s_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        radius_scaled;
  logic [17:0]        polar_angle;
  logic signed [18:0] azimuth;
  logic signed [31:0] time_scaled;
  logic               inside_res;
  modport source (output valid, radius_scaled, polar_angle, azimuth, time_scaled,
                  inside_res, input ready);
  modport sink   (input valid, radius_scaled, polar_angle, azimuth, time_scaled,
                  inside_res, output ready);
endinterface

>>> rtl/cartesian_to_spherical_map.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_map
// Maps a signed Q16.16 point (x, y, z, t) to scaled radius, polar angle,
// azimuth, scaled time and an inside flag.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  pt_i     in   valid/ready    x_pos y_pos z_pos time_pos
//  res_o    out  valid/ready    radius_scaled polar_angle azimuth time_scaled
//                               inside_res
//  cfg      in   cfg_we_i       cfg_idx_i cfg_data_i
//
//  one point per cycle unless res_o stalls; 2 product and sum stages, 32
//  square root cells, 2 setup stages, 18 cordic cells and the output register
//  each stage holds its beat only while the one after it is full and stalled
//  reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module cartesian_to_spherical_map import c2s_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  c2s_in_if.sink      pt_i,
  c2s_out_if.source   res_o
);

  localparam int S_SQ0  = 2;
  localparam int S_POST = S_SQ0 + SQRT_STEPS;
  localparam int S_NORM = S_POST + 1;
  localparam int S_COR0 = S_NORM + 1;
  localparam int S_OUT  = S_COR0 + CORDIC_STAGES;
  localparam int NST    = S_OUT + 1;

  logic [31:0] radius_max_q, inv_radius_q, omega_q, tolerance_q, time_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_max_q <= 32'd65536;
      inv_radius_q <= 32'd65536;
      omega_q      <= 32'd65536;
      tolerance_q  <= 32'd0;
      time_limit_q <= 32'd205887;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS_MAX: radius_max_q <= cfg_data_i;
        CFG_INV_RADIUS: inv_radius_q <= cfg_data_i;
        CFG_OMEGA:      omega_q      <= cfg_data_i;
        CFG_TOLERANCE:  tolerance_q  <= cfg_data_i;
        CFG_TIME_LIMIT: time_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  v   [NST];
  item_t d   [NST];
  logic  adv [NST];

  assign adv[NST-1] = !v[NST-1] | res_o.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !v[k] | adv[k+1];
  end
  assign pt_i.ready = adv[0];

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : a;
  endfunction

  function automatic lane_t turn(input logic signed [LANE_W-1:0] x,
                                 input logic signed [LANE_W-1:0] y);
    lane_t l;
    l.x = x;
    l.y = y;
    l.acc = '0;
    if (x[LANE_W-1]) begin
      if (!y[LANE_W-1]) begin
        l.x = y;
        l.y = -x;
        l.acc = HALF_PI_Q30;
      end else begin
        l.x = -y;
        l.y = x;
        l.acc = -HALF_PI_Q30;
      end
    end
    return l;
  endfunction

  function automatic lane_t norm(input lane_t l);
    lane_t r;
    logic signed [LANE_W-1:0] ay, m;
    logic [5:0] s;
    ay = l.y[LANE_W-1] ? -l.y : l.y;
    m  = (l.x > ay) ? l.x : ay;
    s  = 6'd41;
    for (int i = 0; i <= 40; i++) begin
      if (m[i]) s = 6'(40 - i);
    end
    if (|m[LANE_W-1:41]) s = '0;
    r   = l;
    r.x = l.x <<< s;
    r.y = l.y <<< s;
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] to_frac(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] mg;
    mg = a[ACC_W-1] ? -a : a;
    mg = (mg + (ACC_W'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
    return a[ACC_W-1] ? -mg : mg;
  endfunction

  // products
  logic  v0_q;
  item_t d0_q, d0_d;
  logic signed [33:0] t_ext, t_lo, t_hi;

  always_comb begin
    d0_d        = '0;
    d0_d.x      = pt_i.x_pos;
    d0_d.y      = pt_i.y_pos;
    d0_d.z      = pt_i.z_pos;
    d0_d.sq_x   = 64'(mag32(pt_i.x_pos)) * 64'(mag32(pt_i.x_pos));
    d0_d.sq_y   = 64'(mag32(pt_i.y_pos)) * 64'(mag32(pt_i.y_pos));
    d0_d.sq_z   = 64'(mag32(pt_i.z_pos)) * 64'(mag32(pt_i.z_pos));
    d0_d.t_prod = 64'(mag32(pt_i.time_pos)) * 64'(omega_q);
    d0_d.t_neg  = pt_i.time_pos[31];
    t_ext = {{2{pt_i.time_pos[31]}}, pt_i.time_pos};
    t_lo  = -$signed({2'b00, tolerance_q});
    t_hi  = $signed({1'b0, {1'b0, time_limit_q} + {1'b0, tolerance_q}});
    d0_d.t_in = (t_ext >= t_lo) && (t_ext <= t_hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv[0]) v0_q <= pt_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv[0]) d0_q <= d0_d;
  end
  assign v[0] = v0_q;
  assign d[0] = d0_q;

  // sums and time saturation
  logic  v1_q;
  item_t d1_q, d1_d;
  logic [63:0] tmag;

  always_comb begin
    d1_d       = d[0];
    d1_d.rem_p = d[0].sq_x + d[0].sq_y;
    d1_d.rem_r = d[0].sq_x + d[0].sq_y + d[0].sq_z;
    d1_d.res_p = '0;
    d1_d.res_r = '0;
    tmag = d[0].t_prod >> FRAC_BITS;
    if (d[0].t_neg) begin
      if (tmag > 64'h8000_0000) tmag = 64'h8000_0000;
      d1_d.ts = 32'(-tmag);
    end else begin
      if (tmag > 64'h7FFF_FFFF) tmag = 64'h7FFF_FFFF;
      d1_d.ts = tmag[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv[1]) v1_q <= v[0];
  end
  always_ff @(posedge clk_i) begin
    if (adv[1]) d1_q <= d1_d;
  end
  assign v[1] = v1_q;
  assign d[1] = d1_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    c2s_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (5'(k)),
      .en_i    (adv[S_SQ0+k]),
      .valid_i (v[S_SQ0+k-1]),
      .item_i  (d[S_SQ0+k-1]),
      .valid_o (v[S_SQ0+k]),
      .item_o  (d[S_SQ0+k])
    );
  end

  // radius product, inside test, quarter turn
  logic  vp_q;
  item_t dp_q, dp_d;
  logic [31:0] air, rho;

  always_comb begin
    dp_d   = d[S_POST-1];
    air    = d[S_POST-1].res_r[31:0];
    rho    = d[S_POST-1].res_p[31:0];
    dp_d.r_prod = 64'(air) * 64'(inv_radius_q);
    dp_d.r_in   = {1'b0, air} <= ({1'b0, radius_max_q} + {1'b0, tolerance_q});
    dp_d.axis   = (rho == '0);
    dp_d.z_neg  = d[S_POST-1].z[31];
    dp_d.th = turn(LANE_W'(d[S_POST-1].z), $signed({{(LANE_W-32){1'b0}}, rho}));
    dp_d.ph = turn(LANE_W'(d[S_POST-1].x), LANE_W'(d[S_POST-1].y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else if (adv[S_POST]) vp_q <= v[S_POST-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv[S_POST]) dp_q <= dp_d;
  end
  assign v[S_POST] = vp_q;
  assign d[S_POST] = dp_q;

  // normalize
  logic  vn_q;
  item_t dn_q, dn_d;

  always_comb begin
    dn_d    = d[S_POST];
    dn_d.th = norm(d[S_POST].th);
    dn_d.ph = norm(d[S_POST].ph);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vn_q <= 1'b0;
    else if (adv[S_NORM]) vn_q <= v[S_POST];
  end
  always_ff @(posedge clk_i) begin
    if (adv[S_NORM]) dn_q <= dn_d;
  end
  assign v[S_NORM] = vn_q;
  assign d[S_NORM] = dn_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    c2s_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (5'(k)),
      .en_i    (adv[S_COR0+k]),
      .valid_i (v[S_COR0+k-1]),
      .item_i  (d[S_COR0+k-1]),
      .valid_o (v[S_COR0+k]),
      .item_o  (d[S_COR0+k])
    );
  end

  // output register
  logic               vo_q;
  logic [31:0]        rs_q, rs_d;
  logic [17:0]        th_q, th_d;
  logic signed [18:0] ph_q, ph_d;
  logic signed [31:0] ts_q;
  logic               in_q, in_d;
  logic [63:0]        rsw;
  logic signed [ACC_W-1:0] th_f, ph_f, pi_s;
  item_t              dl;

  always_comb begin
    dl   = d[S_OUT-1];
    pi_s = $signed({{(ACC_W-18){1'b0}}, PI_F});
    rsw  = dl.r_prod >> FRAC_BITS;
    rs_d = (|rsw[63:32]) ? 32'hFFFF_FFFF : rsw[31:0];
    th_f = to_frac(dl.th.acc);
    ph_f = to_frac(dl.ph.acc);
    if (th_f < 0) th_f = '0;
    if (th_f > pi_s) th_f = pi_s;
    if (ph_f > pi_s) ph_f = pi_s;
    if (ph_f < -pi_s) ph_f = -pi_s;
    if (dl.axis) begin
      th_f = dl.z_neg ? pi_s : '0;
      ph_f = '0;
    end
    th_d = th_f[17:0];
    ph_d = ph_f[18:0];
    in_d = dl.r_in & dl.t_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (adv[S_OUT]) vo_q <= v[S_OUT-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv[S_OUT]) begin
      rs_q <= rs_d;
      th_q <= th_d;
      ph_q <= ph_d;
      ts_q <= dl.ts;
      in_q <= in_d;
    end
  end
  assign v[S_OUT] = vo_q;
  assign d[S_OUT] = dl;

  assign res_o.valid         = vo_q;
  assign res_o.radius_scaled = rs_q;
  assign res_o.polar_angle   = th_q;
  assign res_o.azimuth       = ph_q;
  assign res_o.time_scaled   = ts_q;
  assign res_o.inside_res    = in_q;

`ifndef SYNTH
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_i.valid && pt_i.ready |=> v[0])
    else $error("accepted beat missing in first stage");
  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.polar_angle <= PI_F)
    else $error("polar angle beyond pi");
  a_azimuth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ($signed(res_o.azimuth) <= $signed({1'b0, PI_F}) &&
                     $signed(res_o.azimuth) >= -$signed({1'b0, PI_F})))
    else $error("azimuth beyond pi");
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vo_q |-> pt_i.ready)
    else $error("input stalled with empty output");
`endif

endmodule

>>> rtl/c2s_sqrt_cell.sv
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// One restoring square root step for the radius and the cylinder radius.
// ----------------------------------------------------------------------------
module c2s_sqrt_cell import c2s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] step_i,
  input  logic       en_i,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q, item_d;
  logic [63:0] bit_w;

  always_comb begin
    bit_w = 64'd1 << (6'd62 - {step_i, 1'b0});
    item_d = item_i;
    if (item_i.rem_r >= item_i.res_r + bit_w) begin
      item_d.rem_r = item_i.rem_r - (item_i.res_r + bit_w);
      item_d.res_r = (item_i.res_r >> 1) + bit_w;
    end else begin
      item_d.res_r = item_i.res_r >> 1;
    end
    if (item_i.rem_p >= item_i.res_p + bit_w) begin
      item_d.rem_p = item_i.rem_p - (item_i.res_p + bit_w);
      item_d.res_p = (item_i.res_p >> 1) + bit_w;
    end else begin
      item_d.res_p = item_i.res_p >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/c2s_cordic_cell.sv
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// One vectoring rotation for the polar and the azimuth lanes.
// ----------------------------------------------------------------------------
module c2s_cordic_cell import c2s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] idx_i,
  input  logic       en_i,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q, item_d;

  function automatic lane_t rotate(input lane_t l, input logic [4:0] i);
    lane_t r;
    logic signed [LANE_W-1:0] dx, dy;
    dx = l.y >>> i;
    dy = l.x >>> i;
    r  = l;
    if (!l.y[LANE_W-1]) begin
      r.x   = l.x + dx;
      r.y   = l.y - dy;
      r.acc = l.acc + atan_q30(i);
    end else begin
      r.x   = l.x - dx;
      r.y   = l.y + dy;
      r.acc = l.acc - atan_q30(i);
    end
    return r;
  endfunction

  always_comb begin
    item_d    = item_i;
    item_d.th = rotate(item_i.th, idx_i);
    item_d.ph = rotate(item_i.ph, idx_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
